### hdl/sbb_pkg.sv
// ----------------------------------------------------------------------------
// sbb_pkg
// Types and constants shared by the spectrum bar ballistics block.
// ----------------------------------------------------------------------------
package sbb_pkg;

  localparam int LEVEL_W   = 7;
  localparam int HOLD_W    = 8;
  localparam int PIXEL_W   = 8;
  localparam int BAND_IN_W = 5;
  localparam int REV_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_HOLD_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_MAX_HEIGHT  = 1'd1;

  localparam logic [HOLD_W-1:0]  PEAK_HOLD_RESET = 8'd18;
  localparam logic [PIXEL_W-1:0] BAR_MAX_RESET   = 8'd79;

  // floor(p / 100) == (p * DIV100_K) >> DIV100_SH for every product below 2^15.
  localparam int PROD_W     = LEVEL_W + PIXEL_W;
  localparam int DIV100_K_W = 13;
  localparam logic [DIV100_K_W-1:0] DIV100_K = 13'd5243;
  localparam int DIV100_SH  = 19;

  // floor(x / 3) == (x * DIV3_K) >> DIV3_SH for every x below 512.
  localparam logic [7:0] DIV3_K = 8'd171;
  localparam int DIV3_SH = 9;

  typedef struct packed {
    logic [LEVEL_W-1:0] target;
    logic [LEVEL_W-1:0] shown;
    logic [LEVEL_W-1:0] peak;
    logic [HOLD_W-1:0]  hold;
  } band_state_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } sbb_state_t;

endpackage

### hdl/spectrum_bar_ballistics_peak_hold.sv
// ----------------------------------------------------------------------------
// spectrum_bar_ballistics_peak_hold
// Bar-graph spectrum ballistics with peak hold over a per-band state memory.
// ----------------------------------------------------------------------------
// A write beat stages one band's target level. A tick beat walks the band memory one band
// per cycle while the output register can take a beat; each result passes the registered read,
// the a and b stages and the output register. No input is taken until the tick is done.
// Reset is synchronous; per-entry valid bits clear both memories at once, so
// there is no clearing pass.
// ----------------------------------------------------------------------------
module spectrum_bar_ballistics_peak_hold #(
  parameter int BANDS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [4:0]                    in_band,
  input  logic [6:0]                    in_target_level,
  input  logic [31:0]                   in_frame_revision,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [4:0]                    out_band_index,
  output logic [7:0]                    out_bar_height,
  output logic [7:0]                    out_peak_height,
  output logic                          out_peak_visible,
  output logic                          out_last_band,
  input  logic                          cfg_we,
  input  logic [sbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata
);
  import sbb_pkg::*;

  localparam int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(BANDS - 1);

  sbb_state_t state_r, state_nxt;

  logic [HOLD_W-1:0]  hold_ticks_r;
  logic [PIXEL_W-1:0] bar_max_r;
  logic               parity_r;
  logic [REV_W-1:0]   seen_rev_r;
  logic               copy_r;
  logic [BAND_W-1:0]  cnt_r;

  band_state_t        band_mem [BANDS];
  logic [LEVEL_W-1:0] staged_mem [BANDS];
  logic [BANDS-1:0]   band_vld_r;
  logic [BANDS-1:0]   staged_vld_r;

  band_state_t        band_rd_r;
  logic               band_rd_vld_r;
  logic [LEVEL_W-1:0] staged_rd_r;
  logic               staged_rd_vld_r;

  logic               in_acc;
  logic               wr_acc;
  logic               tick_acc;
  logic               wr_in_range;
  logic [BAND_W-1:0]  wr_addr;
  logic [LEVEL_W-1:0] wr_level;
  logic               advance;
  logic               step;
  logic               rd_en;
  logic [BAND_W-1:0]  rd_addr;
  logic               copy_now;

  band_state_t        cur_state;
  band_state_t        new_state;

  logic               a_vld_r;
  logic [BAND_W-1:0]  a_band_r;
  logic               a_last_r;
  logic               a_vis_r;
  logic [LEVEL_W-1:0] a_level_r;
  logic [LEVEL_W-1:0] a_peak_r;
  logic               b_vld_r;
  logic [BAND_W-1:0]  b_band_r;
  logic               b_last_r;
  logic               b_vis_r;
  logic               out_valid_r;
  logic [BAND_W-1:0]  out_band_r;
  logic               out_last_r;
  logic               out_vis_r;

  assign in_ready    = (state_r == ST_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign wr_acc      = in_acc && !in_action;
  assign tick_acc    = in_acc && in_action;
  assign wr_in_range = ({2'b00, in_band} < 7'(BANDS));
  assign wr_addr     = BAND_W'(in_band);
  assign wr_level    = (in_target_level > LEVEL_MAX) ? LEVEL_MAX : in_target_level;

  // The whole result pipeline moves only when the output register can take a beat.
  assign advance = !out_valid_r || out_ready;
  assign step    = (state_r == ST_RUN) && advance;

  // The staged frame is copied on the second tick of each pair when the revision moved.
  assign copy_now = parity_r && (in_frame_revision != seen_rev_r);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (tick_acc) begin
      rd_en = 1'b1;
    end else if (step && (cnt_r != LAST_BAND)) begin
      rd_en   = 1'b1;
      rd_addr = cnt_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (tick_acc) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step && (cnt_r == LAST_BAND)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hold_ticks_r <= PEAK_HOLD_RESET;
      bar_max_r    <= BAR_MAX_RESET;
      parity_r     <= 1'b0;
      seen_rev_r   <= '0;
      copy_r       <= 1'b0;
      cnt_r        <= '0;
      band_vld_r   <= '0;
      staged_vld_r <= '0;
      a_vld_r      <= 1'b0;
      b_vld_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PEAK_HOLD_TICKS: hold_ticks_r <= cfg_wdata;
          CFG_BAR_MAX_HEIGHT:  bar_max_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (wr_acc && wr_in_range) begin
        staged_vld_r[wr_addr] <= 1'b1;
      end
      if (tick_acc) begin
        parity_r <= !parity_r;
        copy_r   <= copy_now;
        cnt_r    <= '0;
        if (copy_now) begin
          seen_rev_r <= in_frame_revision;
        end
      end
      if (step) begin
        band_vld_r[cnt_r] <= 1'b1;
        cnt_r             <= cnt_r + 1'b1;
      end
      if (advance) begin
        a_vld_r     <= step;
        b_vld_r     <= a_vld_r;
        out_valid_r <= b_vld_r;
      end
    end
  end

  // Memories and their registered read ports.
  always_ff @(posedge clk) begin
    if (wr_acc && wr_in_range) begin
      staged_mem[wr_addr] <= wr_level;
    end
    if (step) begin
      band_mem[cnt_r] <= new_state;
    end
    if (rd_en) begin
      band_rd_r       <= band_mem[rd_addr];
      band_rd_vld_r   <= band_vld_r[rd_addr];
      staged_rd_r     <= staged_mem[rd_addr];
      staged_rd_vld_r <= staged_vld_r[rd_addr];
    end
  end

  always_comb begin
    cur_state = band_rd_vld_r ? band_rd_r : '0;
    if (copy_r) begin
      cur_state.target = staged_rd_vld_r ? staged_rd_r : '0;
    end
  end

  sbb_ballistics u_ballistics (
    .cur        (cur_state),
    .hold_ticks (hold_ticks_r),
    .nxt        (new_state)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      a_band_r   <= cnt_r;
      a_last_r   <= (cnt_r == LAST_BAND);
      a_vis_r    <= (new_state.peak != '0);
      a_level_r  <= new_state.shown;
      a_peak_r   <= new_state.peak;
      b_band_r   <= a_band_r;
      b_last_r   <= a_last_r;
      b_vis_r    <= a_vis_r;
      out_band_r <= b_band_r;
      out_last_r <= b_last_r;
      out_vis_r  <= b_vis_r;
    end
  end

  sbb_pixel_scale u_pixel_scale (
    .clk        (clk),
    .en         (advance),
    .bar_max    (bar_max_r),
    .bar_level  (a_level_r),
    .peak_level (a_peak_r),
    .bar_px_r   (out_bar_height),
    .peak_px_r  (out_peak_height)
  );

  assign out_valid        = out_valid_r;
  assign out_band_index   = 5'(out_band_r);
  assign out_peak_visible = out_vis_r;
  assign out_last_band    = out_last_r;

endmodule

### hdl/sbb_ballistics.sv
// ----------------------------------------------------------------------------
// sbb_ballistics
// Moves one band toward its target and updates its held peak.
// ----------------------------------------------------------------------------
module sbb_ballistics (
  input  sbb_pkg::band_state_t    cur,
  input  logic [7:0]              hold_ticks,
  output sbb_pkg::band_state_t    nxt
);
  import sbb_pkg::*;

  logic [LEVEL_W-1:0] lv;
  logic [LEVEL_W-1:0] tg;
  logic [LEVEL_W-1:0] gap;
  logic [7:0]         rise_num;
  logic [15:0]        rise_prod;
  logic [7:0]         rise_step;
  logic [7:0]         rise_sum;
  logic [7:0]         fall_num;
  logic [LEVEL_W-1:0] fall_step;
  logic [LEVEL_W-1:0] new_lv;

  assign lv = cur.shown;
  assign tg = cur.target;

  always_comb begin
    gap       = (tg > lv) ? (tg - lv) : (lv - tg);
    rise_num  = {1'b0, gap} + 8'd2;
    rise_prod = rise_num * DIV3_K;
    rise_step = 8'(rise_prod >> DIV3_SH);
    if (rise_step < 8'd2) begin
      rise_step = 8'd2;
    end
    rise_sum  = {1'b0, lv} + rise_step;
    fall_num  = {1'b0, gap} + 8'd7;
    fall_step = LEVEL_W'(fall_num >> 3);
    if (fall_step == '0) begin
      fall_step = LEVEL_W'(1);
    end

    if (tg > lv) begin
      new_lv = (rise_sum > {1'b0, tg}) ? tg : rise_sum[LEVEL_W-1:0];
    end else if (lv > tg) begin
      new_lv = (lv > fall_step) ? (lv - fall_step) : '0;
    end else begin
      new_lv = lv;
    end

    nxt        = cur;
    nxt.shown  = new_lv;
    if (new_lv >= cur.peak) begin
      nxt.peak = new_lv;
      nxt.hold = hold_ticks;
    end else if (cur.hold != '0) begin
      nxt.hold = cur.hold - 1'b1;
    end else if (cur.peak != '0) begin
      nxt.peak = cur.peak - 1'b1;
    end
  end

endmodule

### hdl/sbb_pixel_scale.sv
// ----------------------------------------------------------------------------
// sbb_pixel_scale
// Two-stage scaler from level percent to pixels for the bar and the peak.
// ----------------------------------------------------------------------------
module sbb_pixel_scale (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] bar_max,
  input  logic [6:0] bar_level,
  input  logic [6:0] peak_level,
  output logic [7:0] bar_px_r,
  output logic [7:0] peak_px_r
);
  import sbb_pkg::*;

  localparam int SCALED_W = PROD_W + DIV100_K_W;

  logic [PROD_W-1:0]   bar_prod_r;
  logic [PROD_W-1:0]   peak_prod_r;
  logic [SCALED_W-1:0] bar_scaled;
  logic [SCALED_W-1:0] peak_scaled;

  assign bar_scaled  = bar_prod_r * DIV100_K;
  assign peak_scaled = peak_prod_r * DIV100_K;

  // The division by 100 is a reciprocal multiply one stage after the scale.
  always_ff @(posedge clk) begin
    if (en) begin
      bar_prod_r  <= bar_level * bar_max;
      peak_prod_r <= peak_level * bar_max;
      bar_px_r    <= bar_scaled[DIV100_SH +: PIXEL_W];
      peak_px_r   <= peak_scaled[DIV100_SH +: PIXEL_W];
    end
  end

endmodule
